FILE: rtl/core/tsoa_pkg.sv
// ============================================================================
// tsoa_pkg: shared definitions for the three-stack store
// Command and status codes, field widths, parameter defaults and the
// controller/datapath command and status structs.
// ============================================================================
package tsoa_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MID   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_MID    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    localparam logic [1:0] TOP_LEFT  = 2'd0;
    localparam logic [1:0] TOP_MID   = 2'd1;
    localparam logic [1:0] TOP_RIGHT = 2'd2;

    typedef struct packed {
        logic                capture;
        logic                idx_init;
        logic                shift_rd;
        logic                shift_wr;
        logic                push_wr;
        logic                ptr_upd;
        logic                top_rd;
        logic [1:0]          top_rd_sel;
        logic                top_cap;
        logic [1:0]          top_cap_sel;
        logic                status_ld;
        logic [STATUS_W-1:0] status_val;
        logic                out_load;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             left_zero;
        logic             mid_zero;
        logic             right_zero;
        logic             shift_more;
        logic             out_free;
    } stat_t;

endpackage

FILE: rtl/core/tsoa_req_if.sv
// ============================================================================
// tsoa_req_if: request channel
// Valid/ready channel carrying one command and its push value.
// ============================================================================
interface tsoa_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [tsoa_pkg::CMD_W-1:0]           cmd;
    logic signed [tsoa_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink (input valid, input cmd, input push_value, output ready);
endinterface

FILE: rtl/core/tsoa_rsp_if.sv
// ============================================================================
// tsoa_rsp_if: response channel
// Valid/ready channel carrying status, three top values and three counts.
// ============================================================================
interface tsoa_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [tsoa_pkg::STATUS_W-1:0]        status;
    logic signed [tsoa_pkg::VALUE_W-1:0]  left_top_value;
    logic signed [tsoa_pkg::VALUE_W-1:0]  mid_top_value;
    logic signed [tsoa_pkg::VALUE_W-1:0]  right_top_value;
    logic [tsoa_pkg::COUNT_W-1:0]         left_count;
    logic [tsoa_pkg::COUNT_W-1:0]         mid_count;
    logic [tsoa_pkg::COUNT_W-1:0]         right_count;

    modport source (
        output valid, output status,
        output left_top_value, output mid_top_value, output right_top_value,
        output left_count, output mid_count, output right_count,
        input ready
    );
    modport sink (
        input valid, input status,
        input left_top_value, input mid_top_value, input right_top_value,
        input left_count, input mid_count, input right_count,
        output ready
    );
endinterface

FILE: rtl/core/tsoa_datapath.sv
// ============================================================================
// tsoa_datapath: store, stack pointers and result registers
// Holds the shared store, the three stack pointers, the shift index, the
// top-value registers and the response register, all under controller
// command.
// ============================================================================
module tsoa_datapath #(
    parameter int DEPTH      = tsoa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsoa_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tsoa_pkg::ctl_t                       ctl,
    output tsoa_pkg::stat_t                      stat,
    input  logic [tsoa_pkg::CMD_W-1:0]           req_cmd,
    input  logic signed [tsoa_pkg::VALUE_W-1:0]  req_push_value,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic [tsoa_pkg::STATUS_W-1:0]        rsp_status,
    output logic signed [tsoa_pkg::VALUE_W-1:0]  rsp_left_top_value,
    output logic signed [tsoa_pkg::VALUE_W-1:0]  rsp_mid_top_value,
    output logic signed [tsoa_pkg::VALUE_W-1:0]  rsp_right_top_value,
    output logic [tsoa_pkg::COUNT_W-1:0]         rsp_left_count,
    output logic [tsoa_pkg::COUNT_W-1:0]         rsp_mid_count,
    output logic [tsoa_pkg::COUNT_W-1:0]         rsp_right_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = tsoa_pkg::VALUE_W;
    localparam int XW = (DATA_WIDTH > VW) ? DATA_WIDTH : VW;
    localparam int EW = (CW > tsoa_pkg::COUNT_W) ? CW : tsoa_pkg::COUNT_W;

    logic [DATA_WIDTH-1:0]         mem [DEPTH];

    logic [tsoa_pkg::CMD_W-1:0]    cmd_reg;
    logic [DATA_WIDTH-1:0]         value_reg;
    logic [CW-1:0]                 left_end_reg;
    logic [CW-1:0]                 mid_end_reg;
    logic [CW-1:0]                 right_used_reg;
    logic [CW-1:0]                 left_end_next;
    logic [CW-1:0]                 mid_end_next;
    logic [CW-1:0]                 right_used_next;
    logic [CW-1:0]                 idx_reg;
    logic [DATA_WIDTH-1:0]         rd_data_reg;
    logic [VW-1:0]                 left_top_reg;
    logic [VW-1:0]                 mid_top_reg;
    logic [VW-1:0]                 right_top_reg;
    logic [tsoa_pkg::STATUS_W-1:0] status_reg;
    logic                          out_valid_reg;
    logic [tsoa_pkg::STATUS_W-1:0] out_status_reg;
    logic [VW-1:0]                 out_left_top_reg;
    logic [VW-1:0]                 out_mid_top_reg;
    logic [VW-1:0]                 out_right_top_reg;
    logic [tsoa_pkg::COUNT_W-1:0]  out_left_count_reg;
    logic [tsoa_pkg::COUNT_W-1:0]  out_mid_count_reg;
    logic [tsoa_pkg::COUNT_W-1:0]  out_right_count_reg;

    logic                          up_dir;
    logic [CW:0]                   fill_sum;
    logic [CW-1:0]                 rd_ptr;
    logic [CW-1:0]                 wr_ptr;
    logic                          rd_en;
    logic                          wr_en;
    logic [DATA_WIDTH-1:0]         wr_data;
    logic [XW-1:0]                 push_wide;
    logic [XW-1:0]                 rd_wide;
    logic                          cap_empty;
    logic [CW-1:0]                 mid_used;
    logic [EW-1:0]                 left_count_wide;
    logic [EW-1:0]                 mid_count_wide;
    logic [EW-1:0]                 right_count_wide;

    assign up_dir   = (cmd_reg == tsoa_pkg::CMD_PUSH_LEFT);
    assign fill_sum = {1'b0, mid_end_reg} + {1'b0, right_used_reg};
    assign mid_used = mid_end_reg - left_end_reg;

    assign push_wide = XW'($unsigned(req_push_value));
    assign rd_wide   = XW'(rd_data_reg);

    assign stat.cmd         = cmd_reg;
    assign stat.full        = (fill_sum == (CW+1)'(DEPTH));
    assign stat.left_zero   = (left_end_reg == '0);
    assign stat.mid_zero    = (mid_end_reg == left_end_reg);
    assign stat.right_zero  = (right_used_reg == '0);
    assign stat.shift_more  = up_dir ? (idx_reg > left_end_reg)
                                     : (({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, mid_end_reg});
    assign stat.out_free    = !out_valid_reg || rsp_ready;

    // store ports
    always_comb
    begin
        rd_en = ctl.shift_rd || ctl.top_rd;
        if (ctl.shift_rd)
        begin
            rd_ptr = up_dir ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));
        end
        else
        begin
            unique case (ctl.top_rd_sel)
                tsoa_pkg::TOP_LEFT:  rd_ptr = left_end_reg - CW'(1);
                tsoa_pkg::TOP_MID:   rd_ptr = mid_end_reg - CW'(1);
                default:             rd_ptr = CW'(DEPTH) - right_used_reg;
            endcase
        end
    end

    always_comb
    begin
        wr_en   = ctl.shift_wr || ctl.push_wr;
        wr_data = ctl.shift_wr ? rd_data_reg : value_reg;
        if (ctl.shift_wr)
        begin
            wr_ptr = idx_reg;
        end
        else
        begin
            unique case (cmd_reg)
                tsoa_pkg::CMD_PUSH_LEFT: wr_ptr = left_end_reg;
                tsoa_pkg::CMD_PUSH_MID:  wr_ptr = mid_end_reg;
                default:                 wr_ptr = CW'(DEPTH - 1) - right_used_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr[AW-1:0]];
        end
    end

    // pointer update for a command that passed its checks
    always_comb
    begin
        left_end_next   = left_end_reg;
        mid_end_next    = mid_end_reg;
        right_used_next = right_used_reg;
        unique case (cmd_reg)
            tsoa_pkg::CMD_PUSH_LEFT:
            begin
                left_end_next = left_end_reg + CW'(1);
                mid_end_next  = mid_end_reg + CW'(1);
            end
            tsoa_pkg::CMD_PUSH_MID:   mid_end_next    = mid_end_reg + CW'(1);
            tsoa_pkg::CMD_PUSH_RIGHT: right_used_next = right_used_reg + CW'(1);
            tsoa_pkg::CMD_POP_LEFT:
            begin
                left_end_next = left_end_reg - CW'(1);
                mid_end_next  = mid_end_reg - CW'(1);
            end
            tsoa_pkg::CMD_POP_MID:    mid_end_next    = mid_end_reg - CW'(1);
            tsoa_pkg::CMD_POP_RIGHT:  right_used_next = right_used_reg - CW'(1);
            default:                  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_end_reg   <= '0;
            mid_end_reg    <= '0;
            right_used_reg <= '0;
        end
        else if (ctl.ptr_upd)
        begin
            left_end_reg   <= left_end_next;
            mid_end_reg    <= mid_end_next;
            right_used_reg <= right_used_next;
        end
    end

    // request capture and shift index
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= req_cmd;
            value_reg <= push_wide[DATA_WIDTH-1:0];
        end
        if (ctl.idx_init)
        begin
            idx_reg <= up_dir ? mid_end_reg : (left_end_reg - CW'(1));
        end
        else if (ctl.shift_wr)
        begin
            idx_reg <= up_dir ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));
        end
        if (ctl.status_ld)
        begin
            status_reg <= ctl.status_val;
        end
    end

    // top values
    always_comb
    begin
        unique case (ctl.top_cap_sel)
            tsoa_pkg::TOP_LEFT: cap_empty = stat.left_zero;
            tsoa_pkg::TOP_MID:  cap_empty = stat.mid_zero;
            default:            cap_empty = stat.right_zero;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.top_cap)
        begin
            unique case (ctl.top_cap_sel)
                tsoa_pkg::TOP_LEFT: left_top_reg  <= cap_empty ? '0 : rd_wide[VW-1:0];
                tsoa_pkg::TOP_MID:  mid_top_reg   <= cap_empty ? '0 : rd_wide[VW-1:0];
                default:            right_top_reg <= cap_empty ? '0 : rd_wide[VW-1:0];
            endcase
        end
    end

    // response register
    assign left_count_wide  = EW'(left_end_reg);
    assign mid_count_wide   = EW'(mid_used);
    assign right_count_wide = EW'(right_used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg      <= status_reg;
            out_left_top_reg    <= left_top_reg;
            out_mid_top_reg     <= mid_top_reg;
            out_right_top_reg   <= right_top_reg;
            out_left_count_reg  <= left_count_wide[tsoa_pkg::COUNT_W-1:0];
            out_mid_count_reg   <= mid_count_wide[tsoa_pkg::COUNT_W-1:0];
            out_right_count_reg <= right_count_wide[tsoa_pkg::COUNT_W-1:0];
        end
    end

    assign rsp_valid           = out_valid_reg;
    assign rsp_status          = out_status_reg;
    assign rsp_left_top_value  = out_left_top_reg;
    assign rsp_mid_top_value   = out_mid_top_reg;
    assign rsp_right_top_value = out_right_top_reg;
    assign rsp_left_count      = out_left_count_reg;
    assign rsp_mid_count       = out_mid_count_reg;
    assign rsp_right_count     = out_right_count_reg;

endmodule

FILE: rtl/core/tsoa_ctrl.sv
// ============================================================================
// tsoa_ctrl: command sequencer
// Decodes each request, runs the middle-stack shift one entry at a time,
// reads back the three tops and hands the response to the output register.
// ============================================================================
module tsoa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tsoa_pkg::stat_t stat,
    output tsoa_pkg::ctl_t  ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SHIFT_RD = 4'd2;
    localparam logic [3:0] S_SHIFT_WR = 4'd3;
    localparam logic [3:0] S_PUSH     = 4'd4;
    localparam logic [3:0] S_PTR      = 4'd5;
    localparam logic [3:0] S_TOP_L    = 4'd6;
    localparam logic [3:0] S_TOP_M    = 4'd7;
    localparam logic [3:0] S_TOP_R    = 4'd8;
    localparam logic [3:0] S_TOP_CAP  = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.status_ld  = 1'b1;
                ctl.status_val = tsoa_pkg::ST_OK;
                unique case (stat.cmd)
                    tsoa_pkg::CMD_PUSH_LEFT:
                    begin
                        if (stat.full)
                        begin
                            ctl.status_val = tsoa_pkg::ST_OVERFLOW;
                            state_next     = S_TOP_L;
                        end
                        else
                        begin
                            ctl.idx_init = 1'b1;
                            state_next   = S_SHIFT_RD;
                        end
                    end
                    tsoa_pkg::CMD_PUSH_MID, tsoa_pkg::CMD_PUSH_RIGHT:
                    begin
                        if (stat.full)
                        begin
                            ctl.status_val = tsoa_pkg::ST_OVERFLOW;
                            state_next     = S_TOP_L;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    tsoa_pkg::CMD_POP_LEFT:
                    begin
                        if (stat.left_zero)
                        begin
                            ctl.status_val = tsoa_pkg::ST_EMPTY;
                            state_next     = S_TOP_L;
                        end
                        else
                        begin
                            ctl.idx_init = 1'b1;
                            state_next   = S_SHIFT_RD;
                        end
                    end
                    tsoa_pkg::CMD_POP_MID:
                    begin
                        if (stat.mid_zero)
                        begin
                            ctl.status_val = tsoa_pkg::ST_EMPTY;
                            state_next     = S_TOP_L;
                        end
                        else
                        begin
                            state_next = S_PTR;
                        end
                    end
                    tsoa_pkg::CMD_POP_RIGHT:
                    begin
                        if (stat.right_zero)
                        begin
                            ctl.status_val = tsoa_pkg::ST_EMPTY;
                            state_next     = S_TOP_L;
                        end
                        else
                        begin
                            state_next = S_PTR;
                        end
                    end
                    default:
                    begin
                        state_next = S_TOP_L;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    ctl.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else if (stat.cmd == tsoa_pkg::CMD_PUSH_LEFT)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_PTR;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_PUSH:
            begin
                ctl.push_wr = 1'b1;
                ctl.ptr_upd = 1'b1;
                state_next  = S_TOP_L;
            end
            S_PTR:
            begin
                ctl.ptr_upd = 1'b1;
                state_next  = S_TOP_L;
            end
            S_TOP_L:
            begin
                ctl.top_rd     = 1'b1;
                ctl.top_rd_sel = tsoa_pkg::TOP_LEFT;
                state_next     = S_TOP_M;
            end
            S_TOP_M:
            begin
                ctl.top_cap     = 1'b1;
                ctl.top_cap_sel = tsoa_pkg::TOP_LEFT;
                ctl.top_rd      = 1'b1;
                ctl.top_rd_sel  = tsoa_pkg::TOP_MID;
                state_next      = S_TOP_R;
            end
            S_TOP_R:
            begin
                ctl.top_cap     = 1'b1;
                ctl.top_cap_sel = tsoa_pkg::TOP_MID;
                ctl.top_rd      = 1'b1;
                ctl.top_rd_sel  = tsoa_pkg::TOP_RIGHT;
                state_next      = S_TOP_CAP;
            end
            S_TOP_CAP:
            begin
                ctl.top_cap     = 1'b1;
                ctl.top_cap_sel = tsoa_pkg::TOP_RIGHT;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/three_stacks_one_array.sv
// ============================================================================
// three_stacks_one_array: three stacks kept in one shared store
// Left stack grows up from entry 0, middle stack sits right above it, right
// stack grows down from the top entry.
//
//   channel  dir  payload
//   req      in   cmd, push_value
//   rsp      out  status, left/mid/right_top_value, left/mid/right_count
//
// One request at a time. A left push or pop first shifts the middle stack
// one entry at a time, up to DEPTH-1 entries, each read and then written
// back through the store. The next request is taken once the response is
// loaded into the output register. Reset clears the three stack pointers;
// the store is not cleared. A new request is taken while a response waits;
// a stalled response holds the last step.
// ============================================================================
module three_stacks_one_array #(
    parameter int DEPTH      = tsoa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsoa_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tsoa_req_if.sink   req,
    tsoa_rsp_if.source rsp
);

    tsoa_pkg::ctl_t  ctl;
    tsoa_pkg::stat_t stat;

    tsoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tsoa_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctl                 (ctl),
        .stat                (stat),
        .req_cmd             (req.cmd),
        .req_push_value      (req.push_value),
        .rsp_valid           (rsp.valid),
        .rsp_ready           (rsp.ready),
        .rsp_status          (rsp.status),
        .rsp_left_top_value  (rsp.left_top_value),
        .rsp_mid_top_value   (rsp.mid_top_value),
        .rsp_right_top_value (rsp.right_top_value),
        .rsp_left_count      (rsp.left_count),
        .rsp_mid_count       (rsp.mid_count),
        .rsp_right_count     (rsp.right_count)
    );

endmodule
